// ===== rtl/lzc_pkg.sv =====
`default_nettype none
package lzc_pkg;
   localparam int DEF_MAX_WINDOW_BITS = 12;
   localparam int DEF_MAX_LENGTH_BITS = 4;
   localparam int MIN_WINDOW_BITS     = 8;
   localparam int MIN_LENGTH_BITS     = 2;
   localparam int BREAK_EVEN_DIV      = 9;

   localparam int CMD_W      = 2;
   localparam int BYTE_W     = 8;
   localparam int KIND_W     = 2;
   localparam int POS_W      = 12;
   localparam int CODE_W     = 4;
   localparam int HDR_BITS_W = 5;
   localparam int HDR_BE_W   = 4;
   localparam int WB_W       = 4;
   localparam int LB_W       = 3;
   localparam int CSR_DATA_W = 4;
   localparam int CSR_ADDR_W = 1;

   localparam logic [CMD_W-1:0] CMD_DATA  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LITERAL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MATCH   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_END     = 2'd3;

   localparam logic [CSR_ADDR_W-1:0] REG_WINDOW_BITS = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_LENGTH_BITS = 1'b1;

   localparam logic [WB_W-1:0] WINDOW_BITS_RESET = 4'd12;
   localparam logic [LB_W-1:0] LENGTH_BITS_RESET = 3'd4;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

   function automatic logic [HDR_BITS_W-1:0] eff_window_bits(input logic [WB_W-1:0] v,
                                                            input int maxv);
      logic [HDR_BITS_W-1:0] r;
      if (v < WB_W'(MIN_WINDOW_BITS)) r = HDR_BITS_W'(MIN_WINDOW_BITS);
      else if (int'(v) > maxv) r = HDR_BITS_W'(maxv);
      else r = HDR_BITS_W'(v);
      return r;
   endfunction

   function automatic logic [LB_W-1:0] eff_length_bits(input logic [LB_W-1:0] v,
                                                      input int maxv);
      logic [LB_W-1:0] r;
      if (v < LB_W'(MIN_LENGTH_BITS)) r = LB_W'(MIN_LENGTH_BITS);
      else if (int'(v) > maxv) r = LB_W'(maxv);
      else r = v;
      return r;
   endfunction

   function automatic logic [HDR_BE_W-1:0] match_threshold(input logic [HDR_BITS_W-1:0] wb,
                                                           input logic [LB_W-1:0] lb);
      logic [5:0] s;
      logic [HDR_BE_W-1:0] r;
      s = 6'd1 + 6'(wb) + 6'(lb);
      if (s >= 6'(2 * BREAK_EVEN_DIV)) r = HDR_BE_W'(2);
      else if (s >= 6'(BREAK_EVEN_DIV)) r = HDR_BE_W'(1);
      else r = '0;
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/lzc_ifs.sv =====
`default_nettype none
interface lzc_req_if import lzc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [BYTE_W-1:0] data_byte;
   modport source(output valid, command, data_byte, input ready);
   modport sink(input valid, command, data_byte, output ready);
endinterface

interface lzc_rsp_if import lzc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [KIND_W-1:0]     kind;
   logic [BYTE_W-1:0]     literal;
   logic [POS_W-1:0]      position;
   logic [CODE_W-1:0]     length_code;
   logic [HDR_BITS_W-1:0] header_window_bits;
   logic [HDR_BITS_W-1:0] header_length_bits;
   logic [HDR_BE_W-1:0]   header_break_even;
   logic                  last;
   modport source(output valid, kind, literal, position, length_code, header_window_bits,
                  header_length_bits, header_break_even, last, input ready);
   modport sink(input valid, kind, literal, position, length_code, header_window_bits,
                header_length_bits, header_break_even, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/lzc_cell.sv =====
`default_nettype none
module lzc_cell import lzc_pkg::*; #(
   parameter int IDX = 0,
   parameter int LW  = 5,
   parameter int AW  = 12
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cell_ctrl_type     ctrl,
   input  wire logic [LW-1:0]     cnt,
   input  wire logic [BYTE_W-1:0] stream,
   input  wire logic [BYTE_W-1:0] load_byte,
   input  wire logic [BYTE_W-1:0] look_next,
   output logic      [BYTE_W-1:0] look,
   input  wire logic              cand_i,
   input  wire logic [LW-1:0]     len_i,
   input  wire logic [AW-1:0]     pos_i,
   output logic                   cand_o,
   output logic      [LW-1:0]     len_o,
   output logic      [AW-1:0]     pos_o
);
   logic [BYTE_W-1:0] look_ff;
   logic              cand_ff;
   logic [LW-1:0]     len_ff;
   logic [AW-1:0]     pos_ff;
   logic              extend_in;

   assign extend_in = cand_i && (len_i == LW'(IDX)) && (LW'(IDX) < cnt) && (stream == look_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff <= 1'b0;
      end else begin
         cand_ff <= cand_i;
      end
      len_ff <= len_i + LW'(extend_in);
      pos_ff <= pos_i;
      if (ctrl.shift) begin
         look_ff <= look_next;
      end else if (ctrl.load && cnt == LW'(IDX)) begin
         look_ff <= load_byte;
      end
   end

   assign look   = look_ff;
   assign cand_o = cand_ff;
   assign len_o  = len_ff;
   assign pos_o  = pos_ff;
endmodule
`default_nettype wire

// ===== rtl/lzss_compressor_core.sv =====
// LZSS compressor core.
// req_chan takes one command per item: a data byte, an end-of-event flush or
// a dictionary clear. rsp_chan returns tokens: a header at the start of an
// event, literals and position/length matches, and an end marker after a flush.
// csr_* writes the window width (index 0) and the match length width (index 1);
// each write empties the dictionary as at reset.
// A byte that codes a token streams the window memory once past the NC look-ahead
// cells (2^MAX_LENGTH_BITS plus the largest break-even), one position per cycle;
// then the coded bytes retire one per cycle. The first item of an event adds a
// scan of the valid memory, an invalidation pass when any position is valid,
// and the header token.
// After reset and after every register write the window and valid memories are
// cleared; a clear command sweeps the valid memory. req_chan is not ready
// meanwhile.
// Tokens sit in an output register; a stalled receiver holds the token there
// and the core waits before it issues the next one.
`default_nettype none
module lzss_compressor_core import lzc_pkg::*; #(
   parameter int MAX_WINDOW_BITS = DEF_MAX_WINDOW_BITS,
   parameter int MAX_LENGTH_BITS = DEF_MAX_LENGTH_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   lzc_req_if.sink                    req_chan,
   lzc_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int AW    = MAX_WINDOW_BITS;
   localparam int DEPTH = 1 << AW;
   localparam int NC    = (1 << MAX_LENGTH_BITS)
                          + (1 + MAX_WINDOW_BITS + MAX_LENGTH_BITS) / BREAK_EVEN_DIV;
   localparam int LW    = $clog2(NC + 1);
   localparam int CW    = AW + 1;

   typedef enum logic [3:0] {
      ST_WIPE, ST_CLEAR, ST_IDLE, ST_APPLY, ST_SCAN, ST_INVAL,
      ST_HEADER, ST_SEARCH, ST_DECIDE, ST_STEP, ST_FINISH
   } state_type;

   state_type         state_ff;
   logic [CW-1:0]     n_ff;
   logic [AW-1:0]     cur_ff;
   logic [LW-1:0]     cnt_ff;
   logic [LW-1:0]     step_ff;
   logic [LW-1:0]     best_len_ff;
   logic [AW-1:0]     best_pos_ff;
   logic              header_sent_ff;
   logic              flush_ff;
   logic              any_ff;
   logic [CMD_W-1:0]  cmd_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic [WB_W-1:0]   wb_ff;
   logic [LB_W-1:0]   lb_ff;

   logic                  rsp_valid_ff;
   logic [KIND_W-1:0]     rsp_kind_ff;
   logic [BYTE_W-1:0]     rsp_literal_ff;
   logic [POS_W-1:0]      rsp_position_ff;
   logic [CODE_W-1:0]     rsp_code_ff;
   logic [HDR_BITS_W-1:0] rsp_hwb_ff;
   logic [HDR_BITS_W-1:0] rsp_hlb_ff;
   logic [HDR_BE_W-1:0]   rsp_hbe_ff;
   logic                  rsp_last_ff;

   logic [BYTE_W-1:0] win_mem [DEPTH];
   logic              val_mem [DEPTH];
   logic [BYTE_W-1:0] win_rd_ff;
   logic              val_rd_ff;
   logic              cand_issue_ff;
   logic [AW-1:0]     pos_issue_ff;

   logic              win_we;
   logic [AW-1:0]     win_wa;
   logic [BYTE_W-1:0] win_wd;
   logic              val_we;
   logic [AW-1:0]     val_wa;
   logic              val_wd;
   logic [AW-1:0]     rd_addr;

   logic [HDR_BITS_W-1:0] wb_eff;
   logic [LB_W-1:0]       lb_eff;
   logic [HDR_BE_W-1:0]   be;
   logic [AW-1:0]         mask;
   logic [LW-1:0]         las;
   logic [AW-1:0]         slot;
   logic [AW-1:0]         inv_addr;
   logic [AW-1:0]         search_addr;
   logic [CW-1:0]         search_last;
   logic [CW-1:0]         inval_last;
   logic                  out_free;
   logic                  rsp_issue;
   cell_ctrl_type         cell_ctrl;

   logic              cand_c [NC+1];
   logic [LW-1:0]     len_c  [NC+1];
   logic [AW-1:0]     pos_c  [NC+1];
   logic [BYTE_W-1:0] look_c [NC+1];

   assign wb_eff      = eff_window_bits(wb_ff, MAX_WINDOW_BITS);
   assign lb_eff      = eff_length_bits(lb_ff, MAX_LENGTH_BITS);
   assign be          = match_threshold(wb_eff, lb_eff);
   assign mask        = AW'((CW'(1) << wb_eff) - CW'(1));
   assign las         = (LW'(1) << lb_eff) + LW'(be);
   assign slot        = (cur_ff + AW'(cnt_ff)) & mask;
   assign inv_addr    = (cur_ff - AW'(las) + AW'(1) + n_ff[AW-1:0]) & mask;
   assign search_addr = (cur_ff + n_ff[AW-1:0]) & mask;
   assign search_last = CW'(mask) + CW'(NC) + CW'(1);
   assign inval_last  = (CW'(las) << 1) - CW'(2);
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_issue   = !csr_we && out_free
                        && (state_ff == ST_HEADER || state_ff == ST_DECIDE
                            || state_ff == ST_FINISH);

   assign req_chan.ready = (state_ff == ST_IDLE) && !csr_we;

   always_comb begin
      win_we    = 1'b0;
      win_wa    = n_ff[AW-1:0];
      win_wd    = '0;
      val_we    = 1'b0;
      val_wa    = n_ff[AW-1:0];
      val_wd    = 1'b0;
      rd_addr   = search_addr;
      cell_ctrl = '0;
      unique case (state_ff)
         ST_WIPE: begin
            win_we = 1'b1;
            val_we = 1'b1;
         end
         ST_CLEAR: begin
            val_we = 1'b1;
         end
         ST_APPLY: begin
            if (cmd_ff == CMD_DATA) begin
               win_we         = 1'b1;
               win_wa         = slot;
               win_wd         = byte_ff;
               val_we         = 1'b1;
               val_wa         = slot;
               cell_ctrl.load = 1'b1;
            end
         end
         ST_SCAN: begin
            rd_addr = n_ff[AW-1:0];
         end
         ST_INVAL: begin
            val_we = 1'b1;
            val_wa = inv_addr;
         end
         ST_STEP: begin
            val_we          = (cur_ff != '0);
            val_wa          = cur_ff;
            val_wd          = 1'b1;
            cell_ctrl.shift = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[win_wa] <= win_wd;
      end
      if (val_we) begin
         val_mem[val_wa] <= val_wd;
      end
      win_rd_ff    <= win_mem[rd_addr];
      val_rd_ff    <= val_mem[rd_addr];
      pos_issue_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_issue_ff <= 1'b0;
      end else begin
         cand_issue_ff <= (state_ff == ST_SEARCH) && (n_ff <= CW'(mask));
      end
   end

   assign cand_c[0]  = cand_issue_ff && val_rd_ff;
   assign len_c[0]   = '0;
   assign pos_c[0]   = pos_issue_ff;
   assign look_c[NC] = '0;

   for (genvar k = 0; k < NC; k++) begin : g_cell
      lzc_cell #(
         .IDX(k),
         .LW (LW),
         .AW (AW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl),
         .cnt      (cnt_ff),
         .stream   (win_rd_ff),
         .load_byte(byte_ff),
         .look_next(look_c[k+1]),
         .look     (look_c[k]),
         .cand_i   (cand_c[k]),
         .len_i    (len_c[k]),
         .pos_i    (pos_c[k]),
         .cand_o   (cand_c[k+1]),
         .len_o    (len_c[k+1]),
         .pos_o    (pos_c[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_WIPE;
         n_ff           <= '0;
         cur_ff         <= AW'(1);
         cnt_ff         <= '0;
         header_sent_ff <= 1'b0;
         flush_ff       <= 1'b0;
         any_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         wb_ff          <= WINDOW_BITS_RESET;
         lb_ff          <= LENGTH_BITS_RESET;
      end else begin
         if (rsp_issue) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_addr)
               REG_WINDOW_BITS: wb_ff <= csr_wdata[WB_W-1:0];
               REG_LENGTH_BITS: lb_ff <= csr_wdata[LB_W-1:0];
            endcase
            state_ff <= ST_WIPE;
            n_ff     <= '0;
         end else begin
            unique case (state_ff)
               ST_WIPE, ST_CLEAR: begin
                  if (n_ff == CW'(DEPTH - 1)) begin
                     if (state_ff == ST_WIPE) begin
                        cur_ff <= AW'(1);
                     end
                     cnt_ff         <= '0;
                     header_sent_ff <= 1'b0;
                     flush_ff       <= 1'b0;
                     state_ff       <= ST_IDLE;
                  end else begin
                     n_ff <= n_ff + CW'(1);
                  end
               end
               ST_IDLE: begin
                  if (req_chan.valid) begin
                     cmd_ff   <= req_chan.command;
                     byte_ff  <= req_chan.data_byte;
                     flush_ff <= (req_chan.command == CMD_FLUSH);
                     n_ff     <= '0;
                     any_ff   <= 1'b0;
                     if (req_chan.command == CMD_DATA || req_chan.command == CMD_FLUSH) begin
                        state_ff <= header_sent_ff ? ST_APPLY : ST_SCAN;
                     end else if (req_chan.command == CMD_CLEAR) begin
                        state_ff <= ST_CLEAR;
                     end
                  end
               end
               ST_SCAN: begin
                  if (n_ff != '0) begin
                     any_ff <= any_ff | val_rd_ff;
                  end
                  if (n_ff == CW'(DEPTH)) begin
                     n_ff <= '0;
                     if (any_ff || val_rd_ff) begin
                        state_ff <= ST_INVAL;
                     end else begin
                        cur_ff   <= AW'(1);
                        state_ff <= ST_HEADER;
                     end
                  end else begin
                     n_ff <= n_ff + CW'(1);
                  end
               end
               ST_INVAL: begin
                  if (n_ff == inval_last) begin
                     state_ff <= ST_HEADER;
                  end else begin
                     n_ff <= n_ff + CW'(1);
                  end
               end
               ST_HEADER: begin
                  if (out_free) begin
                     rsp_kind_ff     <= KIND_HEADER;
                     rsp_literal_ff  <= '0;
                     rsp_position_ff <= POS_W'(cur_ff);
                     rsp_code_ff     <= '0;
                     rsp_hwb_ff      <= wb_eff;
                     rsp_hlb_ff      <= HDR_BITS_W'(lb_eff);
                     rsp_hbe_ff      <= be;
                     rsp_last_ff     <= !flush_ff;
                     header_sent_ff  <= 1'b1;
                     state_ff        <= ST_APPLY;
                  end
               end
               ST_APPLY: begin
                  n_ff        <= CW'(1);
                  best_len_ff <= '0;
                  best_pos_ff <= '0;
                  if (cmd_ff == CMD_DATA) begin
                     cnt_ff   <= cnt_ff + LW'(1);
                     state_ff <= (cnt_ff + LW'(1) >= las) ? ST_SEARCH : ST_IDLE;
                  end else begin
                     state_ff <= (cnt_ff != '0) ? ST_SEARCH : ST_FINISH;
                  end
               end
               ST_SEARCH: begin
                  if (cand_c[NC] && len_c[NC] >= best_len_ff) begin
                     best_len_ff <= len_c[NC];
                     best_pos_ff <= pos_c[NC];
                  end
                  if (n_ff == search_last) begin
                     state_ff <= ST_DECIDE;
                  end else begin
                     n_ff <= n_ff + CW'(1);
                  end
               end
               ST_DECIDE: begin
                  if (out_free) begin
                     rsp_hwb_ff   <= '0;
                     rsp_hlb_ff   <= '0;
                     rsp_hbe_ff   <= '0;
                     rsp_last_ff  <= !flush_ff;
                     if (best_len_ff <= LW'(be)) begin
                        rsp_kind_ff     <= KIND_LITERAL;
                        rsp_literal_ff  <= look_c[0];
                        rsp_position_ff <= '0;
                        rsp_code_ff     <= '0;
                        step_ff         <= LW'(1);
                     end else begin
                        rsp_kind_ff     <= KIND_MATCH;
                        rsp_literal_ff  <= '0;
                        rsp_position_ff <= POS_W'(best_pos_ff);
                        rsp_code_ff     <= CODE_W'(best_len_ff - LW'(be) - LW'(1));
                        step_ff         <= best_len_ff;
                     end
                     state_ff <= ST_STEP;
                  end
               end
               ST_STEP: begin
                  cur_ff  <= (cur_ff + AW'(1)) & mask;
                  cnt_ff  <= cnt_ff - LW'(1);
                  step_ff <= step_ff - LW'(1);
                  if (step_ff == LW'(1)) begin
                     n_ff        <= CW'(1);
                     best_len_ff <= '0;
                     best_pos_ff <= '0;
                     if (!flush_ff) begin
                        state_ff <= ST_IDLE;
                     end else begin
                        state_ff <= (cnt_ff != LW'(1)) ? ST_SEARCH : ST_FINISH;
                     end
                  end
               end
               ST_FINISH: begin
                  if (out_free) begin
                     rsp_kind_ff     <= KIND_END;
                     rsp_literal_ff  <= '0;
                     rsp_position_ff <= '0;
                     rsp_code_ff     <= '0;
                     rsp_hwb_ff      <= '0;
                     rsp_hlb_ff      <= '0;
                     rsp_hbe_ff      <= '0;
                     rsp_last_ff     <= 1'b1;
                     header_sent_ff  <= 1'b0;
                     flush_ff        <= 1'b0;
                     state_ff        <= ST_IDLE;
                  end
               end
            endcase
         end
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.kind               = rsp_kind_ff;
   assign rsp_chan.literal            = rsp_literal_ff;
   assign rsp_chan.position           = rsp_position_ff;
   assign rsp_chan.length_code        = rsp_code_ff;
   assign rsp_chan.header_window_bits = rsp_hwb_ff;
   assign rsp_chan.header_length_bits = rsp_hlb_ff;
   assign rsp_chan.header_break_even  = rsp_hbe_ff;
   assign rsp_chan.last               = rsp_last_ff;
endmodule
`default_nettype wire

// ===== rtl/lzc_checker.sv =====
`default_nettype none
module lzc_checker import lzc_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [KIND_W-1:0] rsp_kind,
   input wire logic              rsp_last,
   input wire logic              csr_we
);
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("token shown right after reset");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_END |-> rsp_last)
      else $error("end marker without last");

   a_cfg_busy: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("item taken during dictionary wipe");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_last))
      else $error("stalled token changed");
endmodule

bind lzss_compressor_core lzc_checker u_lzc_checker (
   .clock    (clock),
   .reset    (reset),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_kind (rsp_chan.kind),
   .rsp_last (rsp_chan.last),
   .csr_we   (csr_we)
);
`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none
module tb_top;
   import lzc_pkg::*;

   localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
   localparam int WIN_DEPTH   = 1 << DEF_MAX_WINDOW_BITS;
   localparam int STALL_LIMIT = 100000;
   localparam int SETTLE      = 4400;

   typedef struct {
      logic [KIND_W-1:0]     kind;
      logic [BYTE_W-1:0]     literal;
      logic [POS_W-1:0]      position;
      logic [CODE_W-1:0]     length_code;
      logic [HDR_BITS_W-1:0] hdr_wb;
      logic [HDR_BITS_W-1:0] hdr_lb;
      logic [HDR_BE_W-1:0]   hdr_be;
      logic                  last;
   } token_type;

   class token_scoreboard;
      bit [7:0]    win_bytes[WIN_DEPTH];
      bit          win_valid[WIN_DEPTH];
      int unsigned cur_pos;
      int unsigned pending;
      bit          in_event;
      bit [3:0]    wb_reg;
      bit [2:0]    lb_reg;
      token_type   expected_q[$];
      int          errors;
      int          n_tokens;
      int          n_matches;
      int          n_literals;

      function void wipe();
         foreach (win_bytes[k]) begin
            win_bytes[k] = 0;
            win_valid[k] = 0;
         end
         cur_pos  = 1;
         pending  = 0;
         in_event = 0;
      endfunction

      function void init();
         wb_reg = WINDOW_BITS_RESET;
         lb_reg = LENGTH_BITS_RESET;
         wipe();
      endfunction

      function int unsigned wb();
         int unsigned w;
         w = 32'(wb_reg);
         if (w < MIN_WINDOW_BITS) w = MIN_WINDOW_BITS;
         if (w > DEF_MAX_WINDOW_BITS) w = DEF_MAX_WINDOW_BITS;
         return w;
      endfunction

      function int unsigned lb();
         int unsigned l;
         l = 32'(lb_reg);
         if (l < MIN_LENGTH_BITS) l = MIN_LENGTH_BITS;
         if (l > DEF_MAX_LENGTH_BITS) l = DEF_MAX_LENGTH_BITS;
         return l;
      endfunction

      function int unsigned mask();
         return (1 << wb()) - 1;
      endfunction

      function int unsigned brk();
         return (1 + wb() + lb()) / BREAK_EVEN_DIV;
      endfunction

      function int unsigned la_size();
         return (1 << lb()) + brk();
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
         if (idx == REG_WINDOW_BITS) wb_reg = v;
         else lb_reg = v[2:0];
         wipe();
      endfunction

      function void push(logic [1:0] kind, int unsigned lit, int unsigned pos,
                         int unsigned code, int unsigned hw, int unsigned hl,
                         int unsigned hb);
         token_type t;
         t.kind = kind; t.literal = BYTE_W'(lit); t.position = POS_W'(pos);
         t.length_code = CODE_W'(code);
         t.hdr_wb = HDR_BITS_W'(hw); t.hdr_lb = HDR_BITS_W'(hl); t.hdr_be = HDR_BE_W'(hb);
         t.last = 1'b0;
         expected_q.push_back(t);
      endfunction

      function void open_event();
         bit          any;
         int unsigned las;
         any = 0;
         las = la_size();
         foreach (win_valid[k]) any |= win_valid[k];
         if (!any) cur_pos = 1;
         else for (int unsigned k = 0; k + 1 < 2 * las; k++)
            win_valid[(cur_pos - (las - 1) + k) & mask()] = 0;
         in_event = 1;
         push(KIND_HEADER, 0, cur_pos, 0, wb(), lb(), brk());
      endfunction

      function void code_one();
         int unsigned m, cur, best_len, best_pos, p, len, run;
         m = mask();
         cur = cur_pos & m;
         best_len = 0;
         best_pos = 0;
         if (pending == 0) return;
         for (int unsigned d = 1; d <= m; d++) begin
            p = (cur - d) & m;
            if (win_valid[p]) begin
               len = 0;
               while (len < pending &&
                      win_bytes[(p + len) & m] == win_bytes[(cur + len) & m]) len++;
               if (len > best_len) begin
                  best_len = len;
                  best_pos = p;
               end
            end
         end
         if (best_len <= brk()) begin
            push(KIND_LITERAL, 32'(win_bytes[cur]), 0, 0, 0, 0, 0);
            run = 1;
         end else begin
            push(KIND_MATCH, 0, best_pos, best_len - (brk() + 1), 0, 0, 0);
            run = best_len;
         end
         for (int unsigned i = 0; i < run; i++) begin
            if (cur != 0) win_valid[cur] = 1;
            cur = (cur + 1) & m;
         end
         cur_pos = cur;
         pending -= run;
      endfunction

      function void note_input(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b);
         int unsigned before_n, slot;
         before_n = expected_q.size();
         if (cmd == CMD_DATA) begin
            if (!in_event) open_event();
            slot = (cur_pos + pending) & mask();
            win_bytes[slot] = b;
            win_valid[slot] = 0;
            pending++;
            if (pending >= la_size()) code_one();
         end else if (cmd == CMD_FLUSH) begin
            if (!in_event) open_event();
            while (pending > 0) code_one();
            push(KIND_END, 0, 0, 0, 0, 0, 0);
            in_event = 0;
         end else if (cmd == CMD_CLEAR) begin
            foreach (win_valid[k]) win_valid[k] = 0;
            pending  = 0;
            in_event = 0;
         end
         if (expected_q.size() > before_n) expected_q[$].last = 1;
      endfunction

      function void check(token_type got);
         token_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected token kind=%0d", got.kind);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         n_tokens++;
         if (e.kind == KIND_MATCH) n_matches++;
         if (e.kind == KIND_LITERAL) n_literals++;
         if (got.kind != e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, got.kind); errors++;
         end
         if (got.literal != e.literal) begin
            $error("literal: expected %0d, got %0d", e.literal, got.literal); errors++;
         end
         if (got.position != e.position) begin
            $error("position: expected %0d, got %0d", e.position, got.position); errors++;
         end
         if (got.length_code != e.length_code) begin
            $error("length_code: expected %0d, got %0d", e.length_code, got.length_code);
            errors++;
         end
         if (got.hdr_wb != e.hdr_wb) begin
            $error("header_window_bits: expected %0d, got %0d", e.hdr_wb, got.hdr_wb);
            errors++;
         end
         if (got.hdr_lb != e.hdr_lb) begin
            $error("header_length_bits: expected %0d, got %0d", e.hdr_lb, got.hdr_lb);
            errors++;
         end
         if (got.hdr_be != e.hdr_be) begin
            $error("header_break_even: expected %0d, got %0d", e.hdr_be, got.hdr_be);
            errors++;
         end
         if (got.last != e.last) begin
            $error("last: expected %0d, got %0d", e.last, got.last); errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lzc_req_if req_chan();
   lzc_rsp_if rsp_chan();

   lzss_compressor_core u_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   token_scoreboard sb;
   bit calm;
   int data_sent;
   int idle_cycles;

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // monitor both channels at the rising edge
   always @(posedge clock) begin
      token_type t;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) sb.note_input(req_chan.command,
                                                             req_chan.data_byte);
         if (rsp_chan.valid && rsp_chan.ready) begin
            t.kind = rsp_chan.kind; t.literal = rsp_chan.literal;
            t.position = rsp_chan.position; t.length_code = rsp_chan.length_code;
            t.hdr_wb = rsp_chan.header_window_bits;
            t.hdr_lb = rsp_chan.header_length_bits;
            t.hdr_be = rsp_chan.header_break_even; t.last = rsp_chan.last;
            sb.check(t);
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // receiver stalls
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         int g;
         g = gap_len();
         repeat (g) begin
            @(negedge clock);
            rsp_chan.ready = 1'b0;
         end
         @(negedge clock);
         rsp_chan.ready = 1'b1;
      end
   end

   task automatic send(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b);
      int g;
      g = gap_len();
      @(negedge clock);
      if (g > 0) begin
         req_chan.valid = 1'b0;
         repeat (g) @(negedge clock);
      end
      req_chan.valid     = 1'b1;
      req_chan.command   = cmd;
      req_chan.data_byte = b;
      do @(posedge clock); while (!req_chan.ready);
      if (cmd == CMD_DATA) data_sent++;
   endtask

   task automatic go_idle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      go_idle();
      @(negedge clock);
      csr_we = 1'b1; csr_addr = idx; csr_wdata = v;
      @(posedge clock);
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // one event: mostly repetitive bytes so that matches occur
   task automatic random_event();
      int n, alpha, base, r;
      logic [7:0] b;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 30);
      alpha = $urandom_range(1, 4);
      base  = $urandom_range(0, 255);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 4) == 0) b = 8'($urandom_range(0, 255));
         else b = 8'(base + $urandom_range(0, alpha - 1));
         if ($urandom_range(0, 49) == 0) send(CMD_IGNORED, 8'($urandom_range(0, 255)));
         send(CMD_DATA, b);
      end
      r = $urandom_range(0, 99);
      if (r < 88) send(CMD_FLUSH, 8'($urandom_range(0, 255)));
      else if (r < 96) send(CMD_CLEAR, 8'($urandom_range(0, 255)));
   endtask

   task automatic random_phase(int quota);
      int target;
      target = data_sent + quota;
      while (data_sent < target) begin
         if ($urandom_range(0, 7) == 0) calm = ~calm;
         random_event();
      end
      calm = 0;
   endtask

   initial begin
      sb = new();
      sb.init();
      reset = 1'b1;
      csr_we = 1'b0; csr_addr = '0; csr_wdata = '0;
      req_chan.valid = 1'b0; req_chan.command = CMD_DATA; req_chan.data_byte = '0;
      calm = 0; data_sent = 0; idle_cycles = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed
      send(CMD_FLUSH, 8'h00);
      send(CMD_DATA, 8'h00);
      send(CMD_DATA, 8'hFF);
      send(CMD_IGNORED, 8'hA5);
      send(CMD_DATA, 8'hAA);
      send(CMD_DATA, 8'h55);
      send(CMD_FLUSH, 8'hFF);
      for (int i = 0; i < 9; i++) send(CMD_DATA, 8'(8'h61 + i % 3));
      send(CMD_FLUSH, 8'h00);
      send(CMD_DATA, 8'h11);
      send(CMD_DATA, 8'h22);
      send(CMD_CLEAR, 8'h00);
      send(CMD_FLUSH, 8'h00);

      random_phase(90);
      write_reg(REG_WINDOW_BITS, 4'd8);
      write_reg(REG_LENGTH_BITS, 4'd2);
      random_phase(90);
      write_reg(REG_LENGTH_BITS, 4'd4);
      random_phase(70);
      write_reg(REG_WINDOW_BITS, 4'd15);
      write_reg(REG_LENGTH_BITS, 4'd0);
      random_phase(70);
      write_reg(REG_WINDOW_BITS, 4'd0);
      write_reg(REG_LENGTH_BITS, 4'd7);
      random_phase(70);
      write_reg(REG_WINDOW_BITS, 4'd10);
      write_reg(REG_LENGTH_BITS, 4'd3);
      random_phase(70);

      go_idle();
      $display("Sent %0d data bytes over six register settings; checked %0d tokens",
               data_sent, sb.n_tokens);
      $display("(%0d literals, %0d matches), %0d mismatches",
               sb.n_literals, sb.n_matches, sb.errors);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== lzss_compressor_core.f =====
rtl/lzc_pkg.sv
rtl/lzc_ifs.sv
rtl/lzc_cell.sv
rtl/lzss_compressor_core.sv
rtl/lzc_checker.sv
bench/tb_top.sv
